### rtl/bcr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package bcr_pkg;

	localparam int VALUE_WIDTH = 32;
	localparam int PROD_W      = 2 * VALUE_WIDTH;
	localparam int FRAC_W      = 16;
	localparam int CLASS_W     = 8;
	localparam int INDEX_W     = 6;
	localparam int WCOUNT_W    = 7;
	localparam int MARGIN_W    = 16;
	localparam int OVL_W       = 7;

	typedef logic [VALUE_WIDTH-1:0] value_t;
	typedef logic [PROD_W-1:0]      prod_t;
	typedef logic [CLASS_W-1:0]     class_t;
	typedef logic [OVL_W-1:0]       ovl_t;

	localparam ovl_t OVL_SAT = {OVL_W{1'b1}};

	localparam logic CMD_LOAD = 1'b0;
	localparam logic CMD_DIST = 1'b1;

	localparam logic [1:0] CFG_WITNESS_COUNT = 2'd0;
	localparam logic [1:0] CFG_MAX_RATIO     = 2'd1;
	localparam logic [1:0] CFG_MARGIN        = 2'd2;

	// one witness entry as held by a cell
	typedef struct packed {
		value_t radius;
		class_t cls;
		value_t distance;
	} entry_t;

	typedef struct packed {
		logic shift;
		logic wr_witness;
		logic wr_dist;
	} cell_ctl_t;

	typedef struct packed {
		logic   no_call;
		class_t assigned_class;
		ovl_t   overlap_count;
	} result_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_CMP,
		ST_LIMIT,
		ST_LIMIT_CMP,
		ST_COUNT,
		ST_DONE
	} state_t;

endpackage
`default_nettype wire

### rtl/bcr_cell.sv
`timescale 1ns / 1ps
`default_nettype none
module bcr_cell (
	input  wire logic              clk,
	input  wire bcr_pkg::cell_ctl_t ctl,
	input  wire bcr_pkg::entry_t   wr_data,
	input  wire bcr_pkg::entry_t   nbr,
	output bcr_pkg::entry_t        entry_q
);
	import bcr_pkg::*;

	// rotate towards the head, or take a load or a distance
	always_ff @(posedge clk) begin
		if (ctl.shift) begin
			entry_q <= nbr;
		end else begin
			if (ctl.wr_witness) begin
				entry_q.radius <= wr_data.radius;
				entry_q.cls    <= wr_data.cls;
			end
			if (ctl.wr_dist) begin
				entry_q.distance <= wr_data.distance;
			end
		end
	end

endmodule
`default_nettype wire

### rtl/bcr_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
module bcr_ctrl #(
	parameter int MAX_WITNESSES = 64,
	localparam int CntW = $clog2(MAX_WITNESSES + 1)
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      start,
	input  wire logic [CntW-1:0]           n_use,
	input  wire bcr_pkg::value_t           max_ratio,
	input  wire logic [bcr_pkg::MARGIN_W-1:0] margin,
	input  wire bcr_pkg::entry_t           head,
	output logic                           idle,
	output logic                           shift,
	output bcr_pkg::result_t               res_q,
	output logic                           res_valid_q,
	input  wire logic                      res_ready
);
	import bcr_pkg::*;

	localparam logic [CntW-1:0] LAST_J = CntW'(MAX_WITNESSES - 1);
	localparam logic [CntW-1:0] END_J  = CntW'(MAX_WITNESSES);

	state_t          state_q, state_d;
	logic [CntW-1:0] j_q;
	value_t          best_d_q, best_r_q;
	class_t          best_cls_q;
	prod_t           prod_a_q, prod_b_q;
	logic            nc_q;
	ovl_t            count_q;
	logic            hit;
	logic            deliver;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		shift   = 1'b0;
		idle    = 1'b0;
		deliver = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				idle = 1'b1;
				if (start) state_d = ST_SCAN;
			end
			ST_SCAN: begin
				if (j_q == END_J) begin
					state_d = ST_LIMIT;
				end else if (j_q != '0 && j_q < n_use) begin
					state_d = ST_CMP;
				end else begin
					shift = 1'b1;
				end
			end
			ST_CMP: begin
				shift   = 1'b1;
				state_d = ST_SCAN;
			end
			ST_LIMIT:     state_d = ST_LIMIT_CMP;
			ST_LIMIT_CMP: state_d = ST_COUNT;
			ST_COUNT: begin
				shift = 1'b1;
				if (j_q == LAST_J) state_d = ST_DONE;
			end
			ST_DONE: begin
				if (!res_valid_q || res_ready) begin
					deliver = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// other-class ball that holds the point by more than the margin
	assign hit = (j_q < n_use) && (head.cls != best_cls_q) && (head.distance < head.radius)
		&& ((head.radius - head.distance) > value_t'(margin)) && (count_q != OVL_SAT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			j_q        <= '0;
			best_d_q   <= '0;
			best_r_q   <= value_t'(1);
		end else begin
			unique case (state_q)
				ST_IDLE: j_q <= '0;
				ST_SCAN: begin
					if (j_q == '0) begin
						best_d_q <= head.distance;
						best_r_q <= head.radius;
						j_q      <= j_q + 1'b1;
					end else if (j_q != END_J && !(j_q < n_use)) begin
						j_q <= j_q + 1'b1;
					end
				end
				ST_CMP: begin
					if (prod_a_q < prod_b_q) begin
						best_d_q <= head.distance;
						best_r_q <= head.radius;
					end
					j_q <= j_q + 1'b1;
				end
				ST_LIMIT:     j_q <= '0;
				ST_COUNT:     j_q <= j_q + 1'b1;
				default:      j_q <= j_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_SCAN: begin
				if (j_q == '0) begin
					best_cls_q <= head.cls;
				end else begin
					prod_a_q <= prod_t'(head.distance) * prod_t'(best_r_q);
					prod_b_q <= prod_t'(best_d_q) * prod_t'(head.radius);
				end
			end
			ST_CMP: begin
				if (prod_a_q < prod_b_q) best_cls_q <= head.cls;
			end
			ST_LIMIT: begin
				prod_a_q <= prod_t'({best_d_q, {FRAC_W{1'b0}}});
				prod_b_q <= prod_t'(max_ratio) * prod_t'(best_r_q);
				count_q  <= '0;
			end
			ST_LIMIT_CMP: nc_q <= !(prod_a_q < prod_b_q);
			ST_COUNT: begin
				if (hit) count_q <= count_q + 1'b1;
			end
			ST_DONE: begin
				if (deliver) begin
					res_q.no_call        <= nc_q;
					res_q.assigned_class <= nc_q ? '0 : best_cls_q;
					res_q.overlap_count  <= count_q;
				end
			end
			default: nc_q <= nc_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (deliver) begin
			res_valid_q <= 1'b1;
		end else if (res_ready) begin
			res_valid_q <= 1'b0;
		end
	end

endmodule
`default_nettype wire

### rtl/ball_cover_ratio_classifier.sv
`timescale 1ns / 1ps
`default_nettype none
// channel   signals                                             direction
// in        in_valid/in_ready, command, witness_index, distance,  into block
//           radius, class_label, last
// out       out_valid/out_ready, no_call, assigned_class,         out of block
//           overlap_count
// cfg       cfg_valid/cfg_ready, cfg_index, cfg_data              into block
//
// A row end rotates the witness ring twice: a ratio pass, which weighs each
// witness in use beyond the first on a shared multiplier pair, a limit check,
// then an overlap pass.
// Reset clears control only; the witness cells have no clearing pass.
// A result waiting at the output holds back only the next row's result.
module ball_cover_ratio_classifier #(
	parameter int MAX_WITNESSES = 64
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         in_valid,
	output logic                              in_ready,
	input  wire logic                         command,
	input  wire logic [bcr_pkg::INDEX_W-1:0]  witness_index,
	input  wire bcr_pkg::value_t              distance,
	input  wire bcr_pkg::value_t              radius,
	input  wire bcr_pkg::class_t              class_label,
	input  wire logic                         last,
	output logic                              out_valid,
	input  wire logic                         out_ready,
	output logic                              no_call,
	output bcr_pkg::class_t                   assigned_class,
	output bcr_pkg::ovl_t                     overlap_count,
	input  wire logic                         cfg_valid,
	output logic                              cfg_ready,
	input  wire logic [1:0]                   cfg_index,
	input  wire logic [31:0]                  cfg_data
);
	import bcr_pkg::*;

	localparam int CntW = $clog2(MAX_WITNESSES + 1);
	localparam int CmpW = (CntW > WCOUNT_W) ? CntW : WCOUNT_W;
	localparam int IdxW = (CntW > INDEX_W) ? CntW : INDEX_W;

	logic [WCOUNT_W-1:0] wcount_q;
	value_t              max_ratio_q;
	logic [MARGIN_W-1:0] margin_q;
	logic [CmpW-1:0]     wcount_ext;
	logic [CntW-1:0]     n_use;
	logic                in_acc;
	logic                row_end;
	logic                idle;
	logic                ring_shift;
	entry_t              wr_data;
	entry_t              cell_q [MAX_WITNESSES];
	result_t             res;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wcount_q    <= WCOUNT_W'(64);
			max_ratio_q <= value_t'(65536);
			margin_q    <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_WITNESS_COUNT: wcount_q    <= cfg_data[WCOUNT_W-1:0];
				CFG_MAX_RATIO:     max_ratio_q <= cfg_data[VALUE_WIDTH-1:0];
				CFG_MARGIN:        margin_q    <= cfg_data[MARGIN_W-1:0];
				default:           wcount_q    <= wcount_q;
			endcase
		end
	end

	// witnesses in use: zero counts as one, clamp to the ring length
	assign wcount_ext = CmpW'(wcount_q);
	assign n_use = (wcount_q == '0) ? CntW'(1) :
		(wcount_ext > CmpW'(MAX_WITNESSES)) ? CntW'(MAX_WITNESSES) : wcount_ext[CntW-1:0];

	assign in_ready = idle;
	assign in_acc   = in_valid && in_ready;
	assign row_end  = in_acc && (command == CMD_DIST) && last;

	assign wr_data.radius   = (radius == '0) ? value_t'(1) : radius;
	assign wr_data.cls      = class_label;
	assign wr_data.distance = distance;

	for (genvar i = 0; i < MAX_WITNESSES; i++) begin : g_cell
		cell_ctl_t ctl;
		logic      sel;

		assign sel            = (IdxW'(witness_index) == IdxW'(i));
		assign ctl.shift      = ring_shift;
		assign ctl.wr_witness = in_acc && sel && (command == CMD_LOAD);
		assign ctl.wr_dist    = in_acc && sel && (command == CMD_DIST);

		bcr_cell u_cell (
			.clk     (clk),
			.ctl     (ctl),
			.wr_data (wr_data),
			.nbr     (cell_q[(i + 1) % MAX_WITNESSES]),
			.entry_q (cell_q[i])
		);
	end

	bcr_ctrl #(
		.MAX_WITNESSES (MAX_WITNESSES)
	) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (row_end),
		.n_use       (n_use),
		.max_ratio   (max_ratio_q),
		.margin      (margin_q),
		.head        (cell_q[0]),
		.idle        (idle),
		.shift       (ring_shift),
		.res_q       (res),
		.res_valid_q (out_valid),
		.res_ready   (out_ready)
	);

	assign no_call        = res.no_call;
	assign assigned_class = res.assigned_class;
	assign overlap_count  = res.overlap_count;

	a_no_write_while_rotating: assert property (@(posedge clk) disable iff (!arst_n)
		ring_shift |-> !in_ready)
		else $error("ring rotates while input is open");

	a_busy_after_row_end: assert property (@(posedge clk) disable iff (!arst_n)
		row_end |=> !in_ready)
		else $error("input still open after row end");

	a_no_call_class_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && no_call) |-> (assigned_class == '0))
		else $error("class given with a no-call");

endmodule
`default_nettype wire
